// ----- hdl/rsc_pkg.sv -----
// shared types and constants for the register stack calculator
package rsc_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned SpWidth    = $clog2(StackDepth + 1);
  localparam int unsigned SaWidth    = $clog2(StackDepth);
  localparam int unsigned CntWidth   = $clog2(DataWidth + 1);

  typedef enum logic [3:0] {
    OpConst    = 4'd0,
    OpPush     = 4'd1,
    OpPop      = 4'd2,
    OpPrintnum = 4'd3,
    OpAdd      = 4'd4,
    OpSub      = 4'd5,
    OpMpy      = 4'd6,
    OpDiv      = 4'd7,
    OpMod      = 4'd8,
    OpLabel    = 4'd9
  } opcode_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StUnder   = 2'd1,
    StOver    = 2'd2,
    StDivZero = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SRead,
    SArith,
    SWrite,
    SOut
  } state_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [2:0]  reg_index;
    logic signed [31:0] immediate;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        print_valid;
    logic signed [31:0] print_value;
    logic [4:0]  stack_depth;
  } rsp_t;

  // command to the serial arithmetic unit
  typedef struct packed {
    logic       start;
    logic [3:0] op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
  } alu_sts_t;

endpackage

// ----- hdl/rsc_alu.sv -----
// bit-serial add, subtract, multiply and signed divide/modulo
module rsc_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rsc_pkg::alu_ctl_t             ctl_i,
  input  logic [rsc_pkg::DataWidth-1:0] x_i,
  input  logic [rsc_pkg::DataWidth-1:0] y_i,
  output rsc_pkg::alu_sts_t             sts_o,
  output logic [rsc_pkg::DataWidth-1:0] res_o
);
  localparam int unsigned W = rsc_pkg::DataWidth;

  logic                               busy_q, busy_d;
  logic [rsc_pkg::CntWidth-1:0]       cnt_q, cnt_d;
  logic [3:0]                         op_q, op_d;
  logic [W-1:0]                       a_q, a_d;   // shifting x / dividend
  logic [W-1:0]                       b_q, b_d;   // shifting y / divisor
  logic [W-1:0]                       acc_q, acc_d;
  logic                               c_q, c_d;
  logic                               negq_q, negq_d, negr_q, negr_d;
  logic                               fin_q, fin_d;
  logic [W:0]                         trial;
  logic [W-1:0]                       rem_sh;
  logic                               sbit, bbit;

  always_comb begin
    rem_sh = {acc_q[W-2:0], a_q[W-1]};
    trial  = {1'b0, rem_sh} - {1'b0, b_q};
    bbit   = (op_q == rsc_pkg::OpSub) ? ~b_q[0] : b_q[0];
    sbit   = a_q[0] ^ bbit ^ c_q;
  end

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; op_d = op_q; a_d = a_q; b_d = b_q;
    acc_d = acc_q; c_d = c_q; negq_d = negq_q; negr_d = negr_q; fin_d = 1'b0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = ctl_i.op;
      acc_d  = '0;
      c_d    = (ctl_i.op == rsc_pkg::OpSub);
      negq_d = x_i[W-1] ^ y_i[W-1];
      negr_d = x_i[W-1];
      if (ctl_i.op == rsc_pkg::OpDiv || ctl_i.op == rsc_pkg::OpMod) begin
        a_d = x_i[W-1] ? (W'(0) - x_i) : x_i;
        b_d = y_i[W-1] ? (W'(0) - y_i) : y_i;
      end else begin
        a_d = x_i;
        b_d = y_i;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      unique case (op_q)
        rsc_pkg::OpAdd, rsc_pkg::OpSub: begin
          // one sum bit a cycle, result shifts in from the top
          acc_d = {sbit, acc_q[W-1:1]};
          c_d   = (a_q[0] & bbit) | (c_q & (a_q[0] ^ bbit));
          a_d   = a_q >> 1;
          b_d   = b_q >> 1;
        end
        rsc_pkg::OpMpy: begin
          // shift-add on the multiplier bit, low bits only
          if (b_q[0]) acc_d = acc_q + a_q;
          a_d = a_q << 1;
          b_d = b_q >> 1;
        end
        default: begin
          // restoring division, quotient collects in a
          if (!trial[W]) begin
            acc_d = trial[W-1:0];
            a_d   = {a_q[W-2:0], 1'b1};
          end else begin
            acc_d = rem_sh;
            a_d   = {a_q[W-2:0], 1'b0};
          end
        end
      endcase
      if (cnt_q == rsc_pkg::CntWidth'(W - 1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; a_q <= a_d; b_q <= b_d; acc_q <= acc_d; c_q <= c_d;
    negq_q <= negq_d; negr_q <= negr_d;
  end

  always_comb begin
    sts_o.done = fin_q;
    case (op_q)
      rsc_pkg::OpDiv: res_o = negq_q ? (W'(0) - a_q) : a_q;
      rsc_pkg::OpMod: res_o = negr_q ? (W'(0) - acc_q) : acc_q;
      default:        res_o = acc_q;
    endcase
  end

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> !fin_q) else $error("alu done held");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q) else $error("alu started while busy");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < rsc_pkg::CntWidth'(W)) else $error("alu count overrun");

endmodule

// ----- hdl/register_stack_calculator.sv -----
// top level of the register stack calculator
// One decoded instruction per request on the input channel (req_valid_i,
// req_stall_o, req_i); one response per request on the output channel
// (rsp_valid_o, rsp_stall_i, rsp_o) with status, print value and depth.
// The block handles one request at a time. Paths from acceptance to the
// response: const, label, push, bad codes and stack errors answer from
// the write state; pop and printnum after one registered stack read; div
// or mod by zero after two reads; add, sub, mpy, div and mod after the
// two operand reads and the 32-step bit-serial arithmetic unit and its
// done flag. A new request is accepted only after the response is taken.
// Reset clears the registers to zero and empties the stack; stack memory
// contents are not cleared and only entries below the stack pointer
// are ever used. While the receiver stalls the response stays on rsp_o
// and no new request is accepted.
module register_stack_calculator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  rsc_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output rsc_pkg::rsp_t rsp_o
);
  localparam int unsigned W = rsc_pkg::DataWidth;

  rsc_pkg::state_e                state_q, state_d;
  rsc_pkg::req_t                  req_q;
  logic [W-1:0]                   regs_q [8];
  logic [W-1:0]                   stack_mem [rsc_pkg::StackDepth];
  logic [rsc_pkg::SpWidth-1:0]    sp_q;
  logic [W-1:0]                   rd_q, x_q;
  logic                           second_q;
  rsc_pkg::rsp_t                  rsp_q;
  logic                           acc;
  logic                           err;
  logic [1:0]                     err_code;
  logic                           need_read;
  rsc_pkg::alu_ctl_t              alu_ctl;
  rsc_pkg::alu_sts_t              alu_sts;
  logic [W-1:0]                   alu_res;
  logic [rsc_pkg::SaWidth-1:0]    rd_addr;

  assign acc = req_valid_i && !req_stall_o;
  assign req_stall_o = (state_q != rsc_pkg::SIdle);
  assign rsp_valid_o = (state_q == rsc_pkg::SOut);
  assign rsp_o = rsp_q;

  // error check from the latched request
  always_comb begin
    err = 1'b0; err_code = rsc_pkg::StOk; need_read = 1'b0;
    unique case (req_q.opcode) inside
      rsc_pkg::OpConst, rsc_pkg::OpLabel: ;
      rsc_pkg::OpPush: begin
        if (sp_q >= rsc_pkg::SpWidth'(rsc_pkg::StackDepth)) begin
          err = 1'b1; err_code = rsc_pkg::StOver;
        end
      end
      rsc_pkg::OpPop, rsc_pkg::OpPrintnum: begin
        if (sp_q == '0) begin
          err = 1'b1; err_code = rsc_pkg::StUnder;
        end else need_read = 1'b1;
      end
      [rsc_pkg::OpAdd:rsc_pkg::OpMod]: begin
        if (sp_q < rsc_pkg::SpWidth'(2)) begin
          err = 1'b1; err_code = rsc_pkg::StUnder;
        end else need_read = 1'b1;
      end
      default: begin
        err = 1'b1; err_code = rsc_pkg::StUnder;
      end
    endcase
  end

  logic is_arith;
  assign is_arith = (req_q.opcode >= rsc_pkg::OpAdd) && (req_q.opcode <= rsc_pkg::OpMod);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsc_pkg::SIdle: if (acc) state_d = rsc_pkg::SWrite;
      rsc_pkg::SWrite: begin
        if (!err && need_read) state_d = rsc_pkg::SRead;
        else state_d = rsc_pkg::SOut;
      end
      rsc_pkg::SRead: begin
        if (!is_arith) state_d = rsc_pkg::SOut;
        else if (second_q) begin
          if ((req_q.opcode == rsc_pkg::OpDiv || req_q.opcode == rsc_pkg::OpMod)
              && rd_q == '0) state_d = rsc_pkg::SOut;
          else state_d = rsc_pkg::SArith;
        end
      end
      rsc_pkg::SArith: if (alu_sts.done) state_d = rsc_pkg::SOut;
      rsc_pkg::SOut: if (!rsp_stall_i) state_d = rsc_pkg::SIdle;
      default: state_d = rsc_pkg::SIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    alu_ctl.start = (state_q == rsc_pkg::SRead) && is_arith && second_q &&
                    (state_d == rsc_pkg::SArith);
    alu_ctl.op    = req_q.opcode;
    // top is read from the write cycle, second from the first read cycle
    rd_addr = (state_q == rsc_pkg::SRead && is_arith)
              ? rsc_pkg::SaWidth'(sp_q - rsc_pkg::SpWidth'(2))
              : rsc_pkg::SaWidth'(sp_q - rsc_pkg::SpWidth'(1));
  end

  rsc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .x_i    (x_q),
    .y_i    (rd_q),
    .sts_o  (alu_sts),
    .res_o  (alu_res)
  );

  // stack memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (state_q == rsc_pkg::SWrite && req_q.opcode == rsc_pkg::OpPush && !err)
      stack_mem[rsc_pkg::SaWidth'(sp_q)] <= regs_q[req_q.reg_index];
    else if (state_q == rsc_pkg::SArith && alu_sts.done)
      stack_mem[rsc_pkg::SaWidth'(sp_q - rsc_pkg::SpWidth'(2))] <= alu_res;
    rd_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (acc) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rsc_pkg::SIdle;
      sp_q     <= '0;
      second_q <= 1'b0;
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        rsc_pkg::SWrite: begin
          second_q <= 1'b0;
          if (!err) begin
            if (req_q.opcode == rsc_pkg::OpConst)
              regs_q[req_q.reg_index] <= req_q.immediate;
            if (req_q.opcode == rsc_pkg::OpPush) sp_q <= sp_q + 1'b1;
          end
        end
        rsc_pkg::SRead: begin
          second_q <= 1'b1;
          if (req_q.opcode == rsc_pkg::OpPop) begin
            regs_q[req_q.reg_index] <= rd_q;
            sp_q <= sp_q - 1'b1;
          end
        end
        rsc_pkg::SArith: if (alu_sts.done) sp_q <= sp_q - 1'b1;
        default: ;
      endcase
    end
  end

  // top of stack kept while the second operand is read
  always_ff @(posedge clk_i) begin
    if (state_q == rsc_pkg::SRead && !second_q) x_q <= rd_q;
  end

  // response register; read data lands in the cycle after its address
  always_ff @(posedge clk_i) begin
    if (state_d == rsc_pkg::SOut && state_q != rsc_pkg::SOut) begin
      rsp_q.status      <= rsc_pkg::StOk;
      rsp_q.print_valid <= 1'b0;
      rsp_q.print_value <= '0;
      rsp_q.stack_depth <= 5'(sp_q);
      if (state_q == rsc_pkg::SWrite) begin
        rsp_q.status <= err_code;
        if (!err && req_q.opcode == rsc_pkg::OpPush)
          rsp_q.stack_depth <= 5'(sp_q + 1'b1);
      end else if (state_q == rsc_pkg::SRead) begin
        if (req_q.opcode == rsc_pkg::OpPrintnum) begin
          rsp_q.print_valid <= 1'b1;
          rsp_q.print_value <= rd_q;
        end else if (req_q.opcode == rsc_pkg::OpPop) begin
          rsp_q.stack_depth <= 5'(sp_q - 1'b1);
        end else begin
          rsp_q.status <= rsc_pkg::StDivZero;
        end
      end else begin
        rsp_q.stack_depth <= 5'(sp_q - 1'b1);
      end
    end
  end

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= rsc_pkg::SpWidth'(rsc_pkg::StackDepth)) else $error("stack pointer overflow");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_stall_i) |=> (rsp_valid_o && $stable(rsp_o)))
    else $error("response changed under stall");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsc_pkg::SArith) |-> req_stall_o) else $error("accept during arith");
  a_sp_steady_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsc_pkg::SOut) |=> $stable(sp_q)) else $error("depth moved after result");

endmodule
